// ===== rtl/pbm_pkg.sv =====
// Shared types, mode codes, rounding and clamp helpers and the soft light square root table for the blend unit.
`timescale 1ns / 1ps
`default_nettype none
package pbm_pkg;

	localparam logic [2:0] MODE_OVER       = 3'd0;
	localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
	localparam logic [2:0] MODE_SCREEN     = 3'd2;
	localparam logic [2:0] MODE_OVERLAY    = 3'd3;
	localparam logic [2:0] MODE_HARD_LIGHT = 3'd4;
	localparam logic [2:0] MODE_SOFT_LIGHT = 3'd5;

	typedef logic [7:0] chan_t;
	typedef logic [255:0][7:0] sqrt_tab_t;

	// Scale by 1/255 with rounding: (p + 127) / 255 for p below 130433
	function automatic logic [8:0] rnd255(input logic [16:0] p);
		logic [17:0] s;
		logic [35:0] m;
		logic [9:0]  q;
		logic [17:0] r;
		begin
			s = {1'b0, p} + 18'd127;
			// Reciprocal rounded down, so the estimate is at most one short
			m = s * 18'd16448;
			q = m[31:22];
			r = s - 18'(q) * 18'd255;
			if (r >= 18'd255) q = q + 10'd1;
			rnd255 = q[8:0];
		end
	endfunction

	// Scale by 1/65025 with rounding: (n + 32512) / 65025 for n below 2^24
	function automatic logic [8:0] rnd65025(input logic [23:0] n);
		logic [24:0] s;
		logic [41:0] m;
		logic [9:0]  q;
		logic [24:0] r;
		begin
			s = {1'b0, n} + 25'd32512;
			// Reciprocal rounded down, so the estimate is at most one short
			m = 42'(s) * 42'd66051;
			q = m[41:32];
			r = s - 25'(q) * 25'd65025;
			if (r >= 25'd65025) q = q + 10'd1;
			rnd65025 = q[8:0];
		end
	endfunction

	// Clamp a wide value to 0..255
	function automatic chan_t clamp8(input logic [9:0] v);
		clamp8 = (v > 10'd255) ? 8'hFF : v[7:0];
	endfunction

	// round(sqrt(255*t)), built at elaboration as a constant table
	function automatic chan_t sqrt_rom(input chan_t t);
		logic [15:0] x;
		logic [8:0]  f;
		begin
			x = 16'd255 * 16'(t);
			f = 9'd0;
			for (int k = 8; k >= 0; k--) begin
				if ((18'(f | (9'd1 << k)) * 18'(f | (9'd1 << k))) <= 18'(x))
					f = f | (9'd1 << k);
			end
			if (18'(x) > 18'(f) * 18'(f) + 18'(f)) f = f + 9'd1;
			sqrt_rom = (f > 9'd255) ? 8'hFF : f[7:0];
		end
	endfunction

	function automatic sqrt_tab_t build_sqrt_tab();
		sqrt_tab_t tab;
		begin
			for (int i = 0; i < 256; i++)
				tab[i] = sqrt_rom(8'(i));
			build_sqrt_tab = tab;
		end
	endfunction

	localparam sqrt_tab_t SQRT_TAB = build_sqrt_tab();

endpackage
`default_nettype wire

// ===== rtl/pbm_div.sv =====
// Pipelined restoring divider for the over mode colour quotient, one bit a stage.
`timescale 1ns / 1ps
`default_nettype none
module pbm_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [16:0] num,
	input  wire logic [8:0]  den,
	output logic [8:0]       quo
);
	import pbm_pkg::*;

	// Quotient is below 512 since num < 2^17 and den >= dividend weight; 9 steps
	logic [16:0] rem_s [0:9];
	logic [8:0]  den_s [0:9];
	logic [8:0]  q_s   [0:9];

	always_comb begin
		rem_s[0] = num;
		den_s[0] = den;
		q_s[0]   = '0;
	end

	genvar g;
	generate
		for (g = 0; g < 9; g++) begin : g_step
			logic [25:0] trial;
			logic        fit;
			assign trial = 26'(den_s[g]) << (8 - g);
			assign fit   = 26'(rem_s[g]) >= trial;
			// Advance one quotient bit, hold on stall
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g+1] <= fit ? 17'(26'(rem_s[g]) - trial) : rem_s[g];
					den_s[g+1] <= den_s[g];
					q_s[g+1]   <= {q_s[g][7:0], fit};
				end
			end
		end
	endgenerate

	assign quo = q_s[9];
endmodule
`default_nettype wire

// ===== rtl/pbm_chan.sv =====
// Per channel blend arithmetic, registered in three stages.
`timescale 1ns / 1ps
`default_nettype none
module pbm_chan (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  t,
	input  wire logic [7:0]  b,
	output logic [7:0]       res
);
	import pbm_pkg::*;

	logic [16:0] p_s1;
	logic        inv_s1;
	logic [16:0] q_s1;
	logic        soft_lo_s1;
	logic [2:0]  mode_s1;
	logic [7:0]  t_s1;
	logic [7:0]  sq_s1;
	logic [8:0]  pp_s1;
	logic [15:0] sa_s1;

	logic [2:0]  mode_s2;
	logic [7:0]  t_s2;
	logic        inv_s2;
	logic        soft_lo_s2;
	logic [16:0] p_s2;
	logic [23:0] lo_s2;
	logic [16:0] hi_s2;

	logic [7:0]  res_s3;

	logic [7:0]  nt, nb, sb_lo;
	logic [16:0] tb, nn;
	assign nt    = 8'd255 - t;
	assign nb    = 8'd255 - b;
	assign sb_lo = 8'd255 - {b[6:0], 1'b0};
	assign tb    = 17'(t) * 17'(b);
	assign nn    = 17'(nt) * 17'(nb);

	// Stage 1: per channel products and square root lookup, select by mode
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1    <= mode;
			t_s1       <= t;
			soft_lo_s1 <= b < 8'd128;
			sq_s1      <= SQRT_TAB[t];
			pp_s1      <= 9'({b, 1'b0} - 9'd255);
			q_s1       <= 17'(t) * 17'(nb);
			sa_s1      <= 16'(t) * 16'(sb_lo);
			inv_s1     <= 1'b0;
			p_s1       <= tb;
			case (mode)
				MODE_SCREEN: begin
					p_s1 <= nn; inv_s1 <= 1'b1;
				end
				MODE_OVERLAY: begin
					p_s1 <= (t < 8'd128) ? tb : nn; inv_s1 <= t >= 8'd128;
				end
				MODE_HARD_LIGHT: begin
					p_s1 <= (b < 8'd128) ? tb : nn; inv_s1 <= b >= 8'd128;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 2: soft light numerators
	// low bottom: 2tb*255 + t^2(255-2b); high bottom: S[t](2b-255) + 2t(255-b)
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2    <= mode_s1;
			t_s2       <= t_s1;
			inv_s2     <= inv_s1;
			soft_lo_s2 <= soft_lo_s1;
			p_s2       <= p_s1;
			lo_s2      <= 24'(p_s1) * 24'd510 + 24'(t_s1) * 24'(sa_s1);
			hi_s2      <= 17'(18'(sq_s1) * 18'(pp_s1) + {q_s1, 1'b0});
		end
	end

	// Stage 3 arithmetic: scale, clamp and select
	logic [9:0]  mul_r, mix2_r;
	logic [9:0]  lo_r, hi_r;
	logic [7:0]  sel;

	assign mul_r  = 10'(rnd255(p_s2));
	// Overlay products stay below 2^16, so doubling fits 17 bits
	assign mix2_r = 10'(rnd255({p_s2[15:0], 1'b0}));
	assign lo_r   = 10'(rnd65025(lo_s2));
	assign hi_r   = 10'(rnd255(hi_s2));

	always_comb begin
		case (mode_s2)
			MODE_MULTIPLY:   sel = clamp8(mul_r);
			MODE_SCREEN:     sel = 8'd255 - clamp8(mul_r);
			MODE_OVERLAY:    sel = inv_s2 ? 8'd255 - clamp8(mix2_r) : clamp8(mix2_r);
			MODE_HARD_LIGHT: sel = inv_s2 ? 8'd255 - clamp8(mix2_r) : clamp8(mix2_r);
			MODE_SOFT_LIGHT: sel = soft_lo_s2 ? clamp8(lo_r) : clamp8(hi_r);
			default:         sel = t_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) res_s3 <= sel;
	end

	assign res = res_s3;
endmodule
`default_nettype wire

// ===== rtl/pixel_blend_mode_unit.sv =====
// Top level of the RGBA blend unit: stream ports, pipeline control and over mode path.
//
// Usage: s_tdata carries one top and one bottom RGBA pixel; m_tdata returns the
// blended RGBA pixel. The blend mode is written through cfg_we / cfg_wdata while
// the unit is idle; reset selects over mode.
// One pixel is taken every cycle unless the full output stage is stalled, set
// by the single pipeline that all channels and the over dividers share. The
// over colour quotient runs through a nine stage bit-per-stage divider, which
// sets the depth.
// Reset clears all valid bits; no transfer is offered until a new input arrives.
// When the receiver holds m_tready low while the output stage is full, the
// whole pipeline holds; a full stage of valid data never drops an item, and
// s_tready falls only while the output stage is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
module pixel_blend_mode_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// top r,g,b,a then bottom r,g,b,a, 8 bits each from bit 0
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out r,g,b,a, 8 bits each from bit 0
	output logic [31:0]      m_tdata
);
	import pbm_pkg::*;

	localparam int DEPTH = 12;

	logic [2:0] mode_q;
	logic [DEPTH-1:0] vld_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_OVER;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	// Advance everything unless the output stage is full and stalled
	assign en       = !(vld_q[DEPTH-1] && !m_tready);
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
	end

	chan_t ta, ba;
	assign ta = s_tdata[31:24];
	assign ba = s_tdata[63:56];

	// Carry the mode of each item along the pipeline
	logic [2:0]  mode_d [0:11];
	always_comb mode_d[0] = mode_q;
	genvar g;
	generate
		for (g = 0; g < 11; g++) begin : g_md
			always_ff @(posedge clk) if (en) mode_d[g+1] <= mode_d[g];
		end
	endgenerate

	// Over path stage 1: background weight
	logic [8:0] w_s1;
	logic [7:0] ta_s1;
	logic [7:0] tc_s1 [0:2];
	logic [7:0] bc_s1 [0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1  <= rnd255(17'(ba) * 17'(8'd255 - ta));
			ta_s1 <= ta;
			for (int i = 0; i < 3; i++) begin
				tc_s1[i] <= s_tdata[8*i +: 8];
				bc_s1[i] <= s_tdata[32 + 8*i +: 8];
			end
		end
	end

	// Over path stage 2: numerators and output alpha
	logic [16:0] num_s2 [0:2];
	logic [8:0]  oa_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			oa_s2 <= 9'(ta_s1) + w_s1;
			for (int i = 0; i < 3; i++)
				num_s2[i] <= 17'(tc_s1[i]) * 17'(ta_s1) + 17'(bc_s1[i]) * 17'(w_s1);
		end
	end

	logic [8:0] quo [0:2];
	generate
		for (g = 0; g < 3; g++) begin : g_div
			pbm_div u_div (.clk(clk), .en(en), .num(num_s2[g]),
				.den(oa_s2 == 9'd0 ? 9'd1 : oa_s2), .quo(quo[g]));
		end
	endgenerate

	// Carry output alpha beside the divider, for the alpha and the zero test at the output
	logic [8:0] oa_d [0:9];
	always_comb oa_d[0] = oa_s2;
	generate
		for (g = 0; g < 9; g++) begin : g_oa
			always_ff @(posedge clk) if (en) oa_d[g+1] <= oa_d[g];
		end
	endgenerate

	// Blend mode channels, then a delay line to line up with the divider
	logic [7:0] bl [0:2];
	generate
		for (g = 0; g < 3; g++) begin : g_ch
			pbm_chan u_ch (.clk(clk), .en(en), .mode(mode_q),
				.t(s_tdata[8*g +: 8]), .b(s_tdata[32 + 8*g +: 8]), .res(bl[g]));
		end
	endgenerate

	logic [7:0] alpha_s2;
	logic [7:0] alpha_s3;
	logic [7:0] ba_s1;
	always_ff @(posedge clk) if (en) ba_s1 <= ba;
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s2 <= (mode_d[1] == MODE_MULTIPLY) ?
				clamp8(10'(rnd255(17'(ta_s1) * 17'(ba_s1)))) : ta_s1;
			alpha_s3 <= alpha_s2;
		end
	end

	logic [31:0] bd [0:8];
	always_comb bd[0] = {alpha_s3, bl[2], bl[1], bl[0]};
	generate
		for (g = 0; g < 8; g++) begin : g_bd
			always_ff @(posedge clk) if (en) bd[g+1] <= bd[g];
		end
	endgenerate

	// Final selection, registered as the output stage
	logic [31:0] out_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			if (mode_d[11] == MODE_OVER) begin
				if (oa_d[9] == 9'd0) out_s12 <= '0;
				else out_s12 <= {clamp8(10'(oa_d[9])), clamp8(10'(quo[2])),
					clamp8(10'(quo[1])), clamp8(10'(quo[0]))};
			end else begin
				out_s12 <= bd[8];
			end
		end
	end

	assign m_tdata = out_s12;

	// Output must hold while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !s_tready)
		else $error("input taken while pipeline held");
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved while held");
endmodule
`default_nettype wire

// ===== test/pixel_blend_mode_unit_tb.sv =====
// Testbench for the RGBA blend unit: random and directed pixels, all modes, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none
module pixel_blend_mode_unit_tb;
	import pbm_pkg::*;

	localparam int LATENCY = 12;

	typedef struct packed {
		chan_t ba, bb, bg, br, ta, tb, tg, tr;
	} pix_pair_t;

	typedef struct packed {
		chan_t a, b, g, r;
	} pix_out_t;

	// Expected blended pixels, oldest first
	class blend_scoreboard;
		pix_out_t pending[$];
		int errors;
		logic [2:0] mode;

		function new();
			errors = 0;
			mode = MODE_OVER;
		endfunction

		function int div255(int p);
			return (p + 127) / 255;
		endfunction

		function int clip(int v);
			return v > 255 ? 255 : v;
		endfunction

		function int root_of(int t);
			int x, f;
			x = 255 * t;
			f = 0;
			while ((f + 1) * (f + 1) <= x) f++;
			if (x > f * f + f) f++;
			return clip(f);
		endfunction

		function int mix_chan(int t, int b);
			int n;
			case (mode)
				MODE_MULTIPLY: return clip(div255(t * b));
				MODE_SCREEN: return 255 - clip(div255((255 - t) * (255 - b)));
				MODE_OVERLAY, MODE_HARD_LIGHT: begin
					if ((mode == MODE_OVERLAY) ? (t < 128) : (b < 128))
						return clip(div255(2 * t * b));
					return 255 - clip(div255(2 * (255 - t) * (255 - b)));
				end
				MODE_SOFT_LIGHT: begin
					if (b < 128) begin
						n = 2 * t * b * 255 + t * t * (255 - 2 * b);
						return clip((n + 32512) / 65025);
					end
					return clip(div255(root_of(t) * (2 * b - 255) + 2 * t * (255 - b)));
				end
				default: return t;
			endcase
		endfunction

		// Note an accepted input and queue its blended pixel
		function void note_input(pix_pair_t p);
			pix_out_t o;
			int w, oa;
			if (mode == MODE_OVER) begin
				w = div255(p.ba * (255 - p.ta));
				oa = p.ta + w;
				if (oa == 0) begin
					o = '0;
				end else begin
					o.r = chan_t'(clip((p.tr * p.ta + p.br * w) / oa));
					o.g = chan_t'(clip((p.tg * p.ta + p.bg * w) / oa));
					o.b = chan_t'(clip((p.tb * p.ta + p.bb * w) / oa));
					o.a = chan_t'(clip(oa));
				end
			end else begin
				o.r = chan_t'(mix_chan(p.tr, p.br));
				o.g = chan_t'(mix_chan(p.tg, p.bg));
				o.b = chan_t'(mix_chan(p.tb, p.bb));
				o.a = (mode == MODE_MULTIPLY) ? chan_t'(clip(div255(p.ta * p.ba))) : p.ta;
			end
			pending.push_back(o);
		endfunction

		// Compare a result transfer with the oldest expectation
		function void check_result(pix_out_t got);
			pix_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.r !== e.r) begin $error("out_red exp %0d got %0d", e.r, got.r); errors++; end
			if (got.g !== e.g) begin $error("out_green exp %0d got %0d", e.g, got.g); errors++; end
			if (got.b !== e.b) begin $error("out_blue exp %0d got %0d", e.b, got.b); errors++; end
			if (got.a !== e.a) begin $error("out_alpha exp %0d got %0d", e.a, got.a); errors++; end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	bit stim_done = 0;

	blend_scoreboard sb = new();

	pixel_blend_mode_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Sample result transfers and draw the receiver stall per item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (m_tready && m_tvalid || !m_tready) begin
				gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 3);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
			end
		end
	end

	// Write the mode register while idle
	task automatic set_mode(logic [2:0] m);
		wait (sb.pending.size() == 0);
		repeat (LATENCY + 2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mode = m;
	endtask

	// Offer one pixel pair, hold until transferred; gap drawn 0..3 when allowed
	task automatic send_pixel(pix_pair_t p, bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
		sb.note_input(p);
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic chan_t edge_val();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			3: return 8'd128;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic pix_pair_t rand_pair();
		pix_pair_t p;
		p = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) begin
			p.tr = edge_val(); p.tg = edge_val(); p.tb = edge_val(); p.ta = edge_val();
			p.br = edge_val(); p.bg = edge_val(); p.bb = edge_val(); p.ba = edge_val();
		end
		return p;
	endfunction

	initial begin
		pix_pair_t p;
		logic [2:0] m;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset mode is over; zero output alpha, extremes, mid thresholds
		send_pixel('0, 0);
		send_pixel({8'd0, 8'd9, 8'd9, 8'd9, 8'd0, 8'd200, 8'd100, 8'd50}, 0);
		send_pixel('1, 0);
		send_pixel({8'd255, 8'd10, 8'd20, 8'd30, 8'd0, 8'd1, 8'd2, 8'd3}, 0);
		send_pixel({8'd128, 8'd255, 8'd0, 8'd127, 8'd127, 8'd128, 8'd255, 8'd0}, 0);
		idle_input();
		for (int k = 1; k <= 7; k++) begin
			set_mode(k[2:0]);
			send_pixel('0, 0);
			send_pixel('1, 0);
			send_pixel({8'd200, 8'd128, 8'd127, 8'd0, 8'd77, 8'd128, 8'd127, 8'd255}, 0);
			idle_input();
		end

		// Random phases through every mode, with one drain pause mid-phase
		for (int ph = 0; ph < 16; ph++) begin
			m = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
			set_mode(m);
			for (int i = 0; i < 28; i++) begin
				if (i == 14 && ph == 3) begin
					idle_input();
					wait (sb.pending.size() == 0);
				end
				send_pixel(rand_pair(), (ph % 3) != 0);
			end
			idle_input();
		end
		set_mode(MODE_OVER);
		stim_done = 1;
	end

	// Finish once drained
	initial begin
		wait (stim_done);
		wait (sb.pending.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("pixel_blend_mode_unit test passed");
		else
			$display("pixel_blend_mode_unit test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("pixel_blend_mode_unit test failed");
		$finish;
	end
endmodule
`default_nettype wire
